>>> rtl/bpc_pkg.sv
package bpc_pkg;

    // register indexes of the configuration port
    localparam logic [2:0] REG_AC1  = 3'd0;
    localparam logic [2:0] REG_AC2  = 3'd1;
    localparam logic [2:0] REG_AC3  = 3'd2;
    localparam logic [2:0] REG_AC4  = 3'd3;
    localparam logic [2:0] REG_B1   = 3'd4;
    localparam logic [2:0] REG_B2   = 3'd5;
    localparam logic [2:0] REG_OSS  = 3'd6;

    // calibration reset values
    localparam logic [15:0] AC1_RESET = 16'd408;
    localparam logic [15:0] AC2_RESET = 16'hFFB8;   // -72
    localparam logic [15:0] AC3_RESET = 16'hC7D1;   // -14383
    localparam logic [15:0] AC4_RESET = 16'd32741;
    localparam logic [15:0] B1_RESET  = 16'd6190;
    localparam logic [15:0] B2_RESET  = 16'd4;
    localparam logic [1:0]  OSS_RESET = 2'd0;

    // compensation constants
    localparam int B5_OFFSET   = 4000;
    localparam int SENS_OFFSET = 32768;
    localparam int PRESS_SCALE = 50000;
    localparam int POLY_X1     = 3038;
    localparam int POLY_X2     = -7357;
    localparam int POLY_C      = 3791;
    localparam int P_MAX       = 262143;
    localparam int P_MIN       = -262144;

    // default depth of the front-to-back queue
    localparam int QUEUE_DEPTH = 4;

    // job handed from front to back
    typedef struct packed {
        logic [16:0] b4;
        logic [31:0] b7;
    } job_t;

endpackage

>>> rtl/bpc_front.sv
module bpc_front (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_wr_en,
    input  logic [2:0]        cfg_index,
    input  logic [15:0]       cfg_wr_data,
    input  logic              in_valid,
    output logic              in_ready,
    input  logic [18:0]       raw_reading,
    input  logic [15:0]       temp_term,
    output logic              job_valid,
    input  logic              job_full,
    output bpc_pkg::job_t     job
);

    logic [15:0] ac1_reg, ac2_reg, ac3_reg, ac4_reg, b1_reg, b2_reg;
    logic [1:0]  oss_reg;

    // calibration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ac1_reg <= bpc_pkg::AC1_RESET;
            ac2_reg <= bpc_pkg::AC2_RESET;
            ac3_reg <= bpc_pkg::AC3_RESET;
            ac4_reg <= bpc_pkg::AC4_RESET;
            b1_reg  <= bpc_pkg::B1_RESET;
            b2_reg  <= bpc_pkg::B2_RESET;
            oss_reg <= bpc_pkg::OSS_RESET;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                bpc_pkg::REG_AC1: ac1_reg <= cfg_wr_data;
                bpc_pkg::REG_AC2: ac2_reg <= cfg_wr_data;
                bpc_pkg::REG_AC3: ac3_reg <= cfg_wr_data;
                bpc_pkg::REG_AC4: ac4_reg <= cfg_wr_data;
                bpc_pkg::REG_B1:  b1_reg  <= cfg_wr_data;
                bpc_pkg::REG_B2:  b2_reg  <= cfg_wr_data;
                bpc_pkg::REG_OSS: oss_reg <= cfg_wr_data[1:0];
                default: ;
            endcase
        end
    end

    logic en;
    logic v1_reg, v2_reg, v3_reg, v4_reg, v5_reg;

    // whole pipeline holds while the last stage cannot enter the queue
    assign en        = !v5_reg || !job_full;
    assign in_ready  = en;
    assign job_valid = v5_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (en) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // stage 1: b6
    logic signed [16:0] b6_reg;
    logic [18:0]        raw1_reg, raw2_reg, raw3_reg, raw4_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            b6_reg   <= $signed({temp_term[15], temp_term}) - 17'sd4000;
            raw1_reg <= raw_reading;
        end
    end

    // stage 2: squared term and linear temperature products
    logic signed [33:0] sq_full, ac2_prod, ac3_prod;
    logic signed [19:0] sq_reg, x1c_reg;
    logic signed [21:0] x2a_reg;

    assign sq_full  = b6_reg * b6_reg;
    assign ac2_prod = $signed({ac2_reg[15], ac2_reg}) * b6_reg;
    assign ac3_prod = $signed({ac3_reg[15], ac3_reg}) * b6_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            sq_reg   <= $signed({1'b0, sq_full[30:12]});
            x2a_reg  <= ac2_prod[32:11];
            x1c_reg  <= ac3_prod[32:13];
            raw2_reg <= raw1_reg;
        end
    end

    // stage 3: quadratic products
    logic signed [35:0] b2_prod, b1_prod;
    logic signed [24:0] x1a_reg;
    logic signed [19:0] x2b_reg, x1c3_reg;
    logic signed [21:0] x2a3_reg;

    assign b2_prod = $signed(b2_reg) * sq_reg;
    assign b1_prod = $signed(b1_reg) * sq_reg;

    always_ff @(posedge aclk) begin
        if (en) begin
            x1a_reg  <= b2_prod[35:11];
            x2b_reg  <= b1_prod[35:16];
            x1c3_reg <= x1c_reg;
            x2a3_reg <= x2a_reg;
            raw3_reg <= raw2_reg;
        end
    end

    // stage 4: offset b3 and sensitivity term
    logic signed [26:0] off_sum;
    logic signed [31:0] off_sh, off_rnd, b3_next;
    logic signed [21:0] sens_sum;
    logic signed [20:0] sens_u;
    logic [31:0]        b3_reg, u_reg;

    always_comb begin
        off_sum  = $signed({ac1_reg[15], ac1_reg, 2'b00}) + 27'(x1a_reg) + 27'(x2a3_reg);
        off_sh   = (32'(off_sum) <<< oss_reg) + 32'sd2;
        off_rnd  = off_sh + (off_sh[31] ? 32'sd3 : 32'sd0);
        b3_next  = off_rnd >>> 2;
        sens_sum = 22'(x1c3_reg) + 22'(x2b_reg) + 22'sd2;
        sens_u   = 21'(sens_sum >>> 2) + 21'(bpc_pkg::SENS_OFFSET);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            b3_reg   <= b3_next;
            u_reg    <= 32'(sens_u);
            raw4_reg <= raw3_reg;
        end
    end

    // stage 5: divisor b4 and scaled dividend b7
    logic [47:0] b4_prod;
    logic [47:0] b7_prod;
    logic [31:0] raw_diff;
    logic [15:0] scale;

    assign b4_prod  = ac4_reg * u_reg;
    assign raw_diff = {13'd0, raw4_reg} - b3_reg;
    assign scale    = 16'(bpc_pkg::PRESS_SCALE) >> oss_reg;
    assign b7_prod  = raw_diff * scale;

    always_ff @(posedge aclk) begin
        if (en) begin
            job.b4 <= b4_prod[31:15];
            job.b7 <= b7_prod[31:0];
        end
    end

endmodule

>>> rtl/bpc_queue.sv
module bpc_queue #(
    parameter int DEPTH = bpc_pkg::QUEUE_DEPTH
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push,
    input  bpc_pkg::job_t push_data,
    output logic          full,
    output logic          pop_valid,
    input  logic          pop,
    output bpc_pkg::job_t pop_data
);

    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    bpc_pkg::job_t   mem [DEPTH];
    logic [IW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [CW-1:0]   count_reg;
    logic            do_push, do_pop;

    assign full      = (count_reg == CW'(DEPTH));
    assign pop_valid = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;
    assign pop_data  = mem[rd_ptr_reg];

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            mem[wr_ptr_reg] <= push_data;
        end
    end

    // pointers and fill count
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= (wr_ptr_reg == IW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= (rd_ptr_reg == IW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

>>> rtl/bpc_back.sv
module bpc_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              job_valid,
    output logic              job_pop,
    input  bpc_pkg::job_t     job,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [18:0]       pressure_pa,
    output logic              divide_error
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_DIV  = 3'd1;
    localparam logic [2:0] ST_PA   = 3'd2;
    localparam logic [2:0] ST_PB   = 3'd3;
    localparam logic [2:0] ST_PC   = 3'd4;

    logic [2:0]  state_reg;
    logic [4:0]  cnt_reg;
    logic [16:0] b4_reg;
    logic [16:0] rem_reg;
    logic [31:0] dq_reg;
    logic        hi_reg, err_reg, sat_reg;
    logic [18:0] p_reg;
    logic [21:0] s_reg;
    logic [17:0] x1_reg;
    logic signed [18:0] x2_reg;
    logic        out_valid_reg;
    logic [18:0] out_p_reg;
    logic        out_err_reg;

    // one restoring division step
    logic [17:0] trial;
    logic        fits;
    logic [31:0] quot;

    assign trial = {rem_reg, dq_reg[31]};
    assign fits  = (trial >= {1'b0, b4_reg});
    assign quot  = hi_reg ? {dq_reg[30:0], 1'b0} : dq_reg;

    // polynomial correction
    logic [33:0]        x1_prod;
    logic signed [34:0] x2_prod;
    logic signed [20:0] t_sum;
    logic signed [21:0] res;
    logic [18:0]        res_sat;
    logic               out_free;

    assign x1_prod  = s_reg * 12'd3038;
    assign x2_prod  = $signed({1'b0, p_reg}) * 15'(bpc_pkg::POLY_X2);
    assign t_sum    = $signed({3'b000, x1_reg}) + 21'(x2_reg) + 21'(bpc_pkg::POLY_C);
    assign res      = $signed({3'b000, p_reg}) + 22'(t_sum >>> 4);
    assign out_free = !out_valid_reg || m_tready;

    always_comb begin
        if (err_reg) begin
            res_sat = '0;
        end else if (sat_reg || res > 22'(bpc_pkg::P_MAX)) begin
            res_sat = 19'(bpc_pkg::P_MAX);
        end else if (res < 22'(bpc_pkg::P_MIN)) begin
            res_sat = 19'(bpc_pkg::P_MIN);
        end else begin
            res_sat = res[18:0];
        end
    end

    assign job_pop      = (state_reg == ST_IDLE) && job_valid;
    assign m_tvalid     = out_valid_reg;
    assign pressure_pa  = out_p_reg;
    assign divide_error = out_err_reg;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg   <= '0;
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (job_valid) begin
                        cnt_reg   <= '0;
                        state_reg <= (job.b4 == '0) ? ST_PC : ST_DIV;
                    end
                end
                ST_DIV: begin
                    cnt_reg <= cnt_reg + 1'b1;
                    if (cnt_reg == 5'd31) begin
                        state_reg <= ST_PA;
                    end
                end
                ST_PA: state_reg <= ST_PB;
                ST_PB: state_reg <= ST_PC;
                ST_PC: begin
                    if (out_free) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge aclk) begin
        case (state_reg)
            ST_IDLE: begin
                b4_reg  <= job.b4;
                rem_reg <= '0;
                hi_reg  <= job.b7[31];
                dq_reg  <= job.b7[31] ? job.b7 : {job.b7[30:0], 1'b0};
                err_reg <= (job.b4 == '0);
                sat_reg <= 1'b0;
            end
            ST_DIV: begin
                rem_reg <= fits ? 17'(trial - {1'b0, b4_reg}) : trial[16:0];
                dq_reg  <= {dq_reg[30:0], fits};
            end
            ST_PA: begin
                sat_reg <= (quot[31:19] != '0);
                p_reg   <= quot[18:0];
                s_reg   <= quot[18:8] * quot[18:8];
            end
            ST_PB: begin
                x1_reg <= x1_prod[33:16];
                x2_reg <= x2_prod[34:16];
            end
            default: ;
        endcase
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (state_reg == ST_PC && out_free) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_PC && out_free) begin
            out_p_reg   <= res_sat;
            out_err_reg <= err_reg;
        end
    end

`ifndef ASSERT_OFF
    // a zero-divisor result carries zero pressure
    a_err_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && out_err_reg |-> out_p_reg == '0)
        else $error("divide error with nonzero pressure");

    // the divide counter only moves while dividing or when a job is taken
    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg != ST_DIV |=> cnt_reg == $past(cnt_reg) || state_reg == ST_DIV
        || $past(state_reg) == ST_IDLE)
        else $error("divide counter moved outside division");

    // a job is taken only while the sequencer is idle
    a_pop_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        job_pop |-> state_reg == ST_IDLE)
        else $error("job popped while busy");

    // a waiting result is not overwritten
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_tready |=> out_valid_reg && $stable(out_p_reg))
        else $error("pending result overwritten");
`endif

endmodule

>>> rtl/barometric_pressure_compensation_core.sv
// Barometric pressure compensation core.
// Input channel s_*: one transaction carries the raw pressure reading and the
// temperature intermediate b5; result channel m_*: one transaction per input
// with the compensated pressure in pascals and a divide error flag in tuser.
// Calibration words and the oversampling setting are written through the
// cfg_wr_en / cfg_index / cfg_wr_data port; the user must write them only
// while no transaction is in flight, as the block does not enforce this.
// A five-stage front computes the divisor b4 and dividend b7 and pushes them
// into a short queue; the back runs a one-bit-per-cycle restoring divider and
// a polynomial correction in states ST_PA, ST_PB and ST_PC. The back takes a
// new job only once it is done with the last one, so the divider and the
// correction set the throughput; the front keeps accepting until the queue fills.
// When m_tready is low the result is held in the output register and the back
// waits; the front and queue keep filling, then s_tready drops.
// Reset (aresetn low, synchronous) empties the pipeline and queue, drops
// m_tvalid and restores the calibration registers to their defaults.
module barometric_pressure_compensation_core #(
    parameter int QUEUE_DEPTH = bpc_pkg::QUEUE_DEPTH
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_wr_en,
    input  logic [2:0]  cfg_index,
    input  logic [15:0] cfg_wr_data,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // raw_reading [18:0], temp_term [34:19]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // pressure_pa [18:0]
    output logic        m_tuser    // divide_error
);

    logic          job_valid, job_full, job_pop, q_valid;
    bpc_pkg::job_t job_in, job_out;
    logic [18:0]   pressure;

    bpc_front u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_tvalid),
        .in_ready    (s_tready),
        .raw_reading (s_tdata[18:0]),
        .temp_term   (s_tdata[34:19]),
        .job_valid   (job_valid),
        .job_full    (job_full),
        .job         (job_in)
    );

    bpc_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (job_valid),
        .push_data (job_in),
        .full      (job_full),
        .pop_valid (q_valid),
        .pop       (job_pop),
        .pop_data  (job_out)
    );

    bpc_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .job_valid    (q_valid),
        .job_pop      (job_pop),
        .job          (job_out),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .pressure_pa  (pressure),
        .divide_error (m_tuser)
    );

    assign m_tdata = {5'd0, pressure};

endmodule

>>> tb/sv/barometric_pressure_compensation_core_tb.sv
module barometric_pressure_compensation_core_tb;

    // calibration set shared by the prediction model
    typedef struct {
        logic signed [15:0] ac1;
        logic signed [15:0] ac2;
        logic signed [15:0] ac3;
        logic [15:0]        ac4;
        logic signed [15:0] b1;
        logic signed [15:0] b2;
        logic [1:0]         oss;
    } calib_t;

    typedef struct {
        logic signed [18:0] pressure;
        logic               div_err;
    } reading_t;

    // arithmetic floor shift on 64-bit values
    function automatic longint fshr(longint x, int n);
        return x >>> n;
    endfunction

    // compensation sequence at the block's widths
    function automatic reading_t compensate(calib_t c, logic [18:0] raw,
                                            logic signed [15:0] b5);
        longint b6, sq, x1, x2, x3, b3, p, t;
        logic [31:0] b4, b7, q, sens;
        reading_t r;
        b6 = longint'(b5) - bpc_pkg::B5_OFFSET;
        sq = fshr(b6 * b6, 12);
        x1 = fshr(longint'(c.b2) * sq, 11);
        x2 = fshr(longint'(c.ac2) * b6, 11);
        x3 = x1 + x2;
        t = (longint'(c.ac1) * 4 + x3) * (longint'(1) << c.oss) + 2;
        b3 = t / 4;
        x1 = fshr(longint'(c.ac3) * b6, 13);
        x2 = fshr(longint'(c.b1) * sq, 16);
        x3 = fshr(x1 + x2 + 2, 2);
        sens = 32'(x3 + bpc_pkg::SENS_OFFSET);
        b4 = (32'(c.ac4) * sens) >> 15;
        b7 = (32'(raw) - 32'(b3)) * (32'(bpc_pkg::PRESS_SCALE) >> c.oss);
        if (b4 == 0) begin
            r.pressure = '0;
            r.div_err = 1'b1;
            return r;
        end
        if (b7 < 32'h8000_0000) q = (b7 * 2) / b4;
        else q = (b7 / b4) * 2;
        p = longint'(q);
        x1 = (p >>> 8) * (p >>> 8);
        x1 = fshr(x1 * bpc_pkg::POLY_X1, 16);
        x2 = fshr(longint'(bpc_pkg::POLY_X2) * p, 16);
        p = p + fshr(x1 + x2 + bpc_pkg::POLY_C, 4);
        if (p > bpc_pkg::P_MAX) p = bpc_pkg::P_MAX;
        if (p < bpc_pkg::P_MIN) p = bpc_pkg::P_MIN;
        r.pressure = 19'(p);
        r.div_err = 1'b0;
        return r;
    endfunction

    // scoreboard of pending pressure readings
    class pressure_board;
        reading_t pending[$];
        int errors;
        int mismatches;

        function void note_input(calib_t c, logic [18:0] raw, logic signed [15:0] b5);
            pending.push_back(compensate(c, raw, b5));
        endfunction

        function void check_result(logic [23:0] data, logic flag);
            reading_t e;
            if (pending.size() == 0) begin
                errors++;
                $display("unexpected result tdata=%h tuser=%b", data, flag);
                return;
            end
            e = pending.pop_front();
            if (data !== {5'd0, e.pressure} || flag !== e.div_err) begin
                errors++;
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: expected p=%0d err=%b, got p=%0d err=%b",
                             e.pressure, e.div_err, $signed(data[18:0]), flag);
            end
        endfunction
    endclass

    logic        aclk = 0;
    logic        aresetn = 0;
    logic        cfg_wr_en = 0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wr_data = '0;
    logic        s_tvalid = 0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;
    logic        m_tvalid;
    logic        m_tready = 0;
    logic [23:0] m_tdata;
    logic        m_tuser;

    pressure_board board = new();
    calib_t cal;
    bit quiet = 0;
    bit hold_sink = 0;
    int sent = 0;

    barometric_pressure_compensation_core dut (.*);

    initial begin
        forever #6 aclk = ~aclk;
    end

    // global timeout
    initial begin
        #60000000;
        $display("barometric_pressure_compensation_core regression: fail");
        $finish;
    end

    // result side with random stalls
    initial begin
        int gap;
        @(posedge aclk iff aresetn);
        forever begin
            if (hold_sink) begin
                m_tready <= 1'b0;
                repeat (400) @(posedge aclk);
                hold_sink = 0;
            end else if (!quiet && $urandom_range(0, 3) == 0) begin
                gap = $urandom_range(1, 7);
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
                if (m_tvalid && m_tready) board.check_result(m_tdata, m_tuser);
            end
        end
    end

    task automatic write_reg(logic [2:0] idx, logic [15:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wr_data <= val;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        case (idx)
            bpc_pkg::REG_AC1: cal.ac1 = val;
            bpc_pkg::REG_AC2: cal.ac2 = val;
            bpc_pkg::REG_AC3: cal.ac3 = val;
            bpc_pkg::REG_AC4: cal.ac4 = val;
            bpc_pkg::REG_B1:  cal.b1 = val;
            bpc_pkg::REG_B2:  cal.b2 = val;
            bpc_pkg::REG_OSS: cal.oss = val[1:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending.size() != 0) @(posedge aclk);
        repeat (60) @(posedge aclk);
    endtask

    task automatic send(logic [18:0] raw, logic [15:0] b5);
        int gap;
        if (!quiet && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {5'd0, b5, raw};
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        board.note_input(cal, raw, b5);
        sent++;
    endtask

    task automatic send_random();
        logic [18:0] raw;
        logic [15:0] b5;
        raw = $urandom_range(0, 3) == 0 ? 19'($urandom) : 19'($urandom_range(15000, 120000));
        b5 = $urandom_range(0, 3) == 0 ? 16'($urandom) : 16'($urandom_range(2000, 6000));
        send(raw, b5);
    endtask

    // random calibration, with extremes sometimes
    task automatic random_calib();
        for (int i = 0; i <= 6; i++) begin
            case ($urandom_range(0, 3))
                0: write_reg(3'(i), 16'h8000);
                1: write_reg(3'(i), 16'h7FFF);
                2: write_reg(3'(i), 16'($urandom));
                default: write_reg(3'(i), 16'hFFFF);
            endcase
        end
        write_reg(bpc_pkg::REG_OSS, 16'($urandom_range(0, 3)));
    endtask

    task automatic default_calib();
        write_reg(bpc_pkg::REG_AC1, bpc_pkg::AC1_RESET);
        write_reg(bpc_pkg::REG_AC2, bpc_pkg::AC2_RESET);
        write_reg(bpc_pkg::REG_AC3, bpc_pkg::AC3_RESET);
        write_reg(bpc_pkg::REG_AC4, bpc_pkg::AC4_RESET);
        write_reg(bpc_pkg::REG_B1, bpc_pkg::B1_RESET);
        write_reg(bpc_pkg::REG_B2, bpc_pkg::B2_RESET);
        write_reg(bpc_pkg::REG_OSS, 16'(bpc_pkg::OSS_RESET));
    endtask

    // stimulus
    initial begin
        cal = '{bpc_pkg::AC1_RESET, bpc_pkg::AC2_RESET, bpc_pkg::AC3_RESET,
                bpc_pkg::AC4_RESET, bpc_pkg::B1_RESET, bpc_pkg::B2_RESET,
                bpc_pkg::OSS_RESET};
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed: field extremes at reset calibration
        send(19'd0, 16'h8000);
        send(19'h7FFFF, 16'h7FFF);
        send(19'd23843, 16'd4703);
        send(19'h7FFFF, 16'h8000);
        send(19'd0, 16'h7FFF);
        send(19'd1, 16'd4000);
        drain();
        // zero divisor via ac4 of zero
        write_reg(bpc_pkg::REG_AC4, 16'd0);
        send(19'd23843, 16'd4703);
        send(19'h7FFFF, 16'h0000);
        drain();
        // extremes of every register, all oversampling settings
        write_reg(bpc_pkg::REG_AC1, 16'h7FFF);
        write_reg(bpc_pkg::REG_AC2, 16'h8000);
        write_reg(bpc_pkg::REG_AC3, 16'h7FFF);
        write_reg(bpc_pkg::REG_AC4, 16'hFFFF);
        write_reg(bpc_pkg::REG_B1, 16'h8000);
        write_reg(bpc_pkg::REG_B2, 16'h7FFF);
        for (int o = 0; o < 4; o++) begin
            write_reg(bpc_pkg::REG_OSS, 16'(o));
            send(19'd0, 16'h8000);
            send(19'h7FFFF, 16'h7FFF);
            send(19'd40000, 16'd4000);
            drain();
        end
        default_calib();

        // random phases with calibration changes
        for (int ph = 0; ph < 10; ph++) begin
            if (ph > 0 && ph % 2 == 0) random_calib();
            else if (ph > 0) default_calib();
            if (ph == 3) begin
                hold_sink = 1;
                repeat (20) send_random();
            end
            if (ph == 8) quiet = 1;
            for (int i = 0; i < 100; i++) send_random();
            drain();
        end

        repeat (20000) begin
            if (board.pending.size() == 0) break;
            @(posedge aclk);
        end
        repeat (60) @(posedge aclk);
        if (board.errors == 0 && board.pending.size() == 0)
            $display("barometric_pressure_compensation_core regression: pass");
        else
            $display("barometric_pressure_compensation_core regression: fail");
        $finish;
    end
endmodule
